/* rtl/core/sort_records_by_string_key_defines.svh */
// Assertion macros shared by the checker.
`ifndef SORT_RECORDS_BY_STRING_KEY_DEFINES_SVH
`define SORT_RECORDS_BY_STRING_KEY_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SRK_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SRK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/srk_pkg.sv */
package srk_pkg;

    localparam int MAX_RECORDS = 1024;
    localparam int KEY_CHARS   = 64;

    localparam int RIDX_W = $clog2(MAX_RECORDS);
    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
    localparam int KPOS_W = $clog2(KEY_CHARS);
    localparam int LEN_W  = $clog2(KEY_CHARS + 1);
    localparam int KEY_AW = RIDX_W + KPOS_W;
    localparam int KEY_DEPTH = MAX_RECORDS * KEY_CHARS;

    // Commands
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_PUSH  = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // Result status
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    // Memory requests from the sort engine
    typedef struct packed {
        logic [KEY_AW-1:0] key_addr;
        logic [RIDX_W-1:0] len_addr;
        logic [RIDX_W-1:0] ord_rd_addr;
        logic              ord_wr_en;
        logic              ord_wr_bank;
        logic [RIDX_W-1:0] ord_wr_addr;
        logic [RIDX_W-1:0] ord_wr_data;
    } srk_req_t;

    // Registered read data back to the sort engine
    typedef struct packed {
        logic [7:0]        key_data;
        logic [LEN_W-1:0]  len_data;
        logic [RIDX_W-1:0] ord_a_data;
        logic [RIDX_W-1:0] ord_b_data;
    } srk_rsp_t;

endpackage

/* rtl/core/srk_ram.sv */
module srk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/srk_sorter.sv */
module srk_sorter (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [srk_pkg::CNT_W-1:0] count,
    input  srk_pkg::srk_rsp_t        rsp,
    output srk_pkg::srk_req_t        req,
    output logic                     done,
    output logic                     bank
);

    localparam int CW = srk_pkg::CNT_W;
    localparam int RW = srk_pkg::RIDX_W;
    localparam int LW = srk_pkg::LEN_W;
    localparam int PW = srk_pkg::KPOS_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_CHUNK = 4'd2;
    localparam logic [3:0] S_SEL   = 4'd3;
    localparam logic [3:0] S_RDP   = 4'd4;
    localparam logic [3:0] S_RDQ   = 4'd5;
    localparam logic [3:0] S_LENP  = 4'd6;
    localparam logic [3:0] S_LENQ  = 4'd7;
    localparam logic [3:0] S_LENC  = 4'd8;
    localparam logic [3:0] S_CHP   = 4'd9;
    localparam logic [3:0] S_CHQ   = 4'd10;
    localparam logic [3:0] S_CMP   = 4'd11;
    localparam logic [3:0] S_WR    = 4'd12;
    localparam logic [3:0] S_CPY   = 4'd13;
    localparam logic [3:0] S_CPYW  = 4'd14;
    localparam logic [3:0] S_DONE  = 4'd15;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] width_reg, width_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] p_reg, p_next;
    logic [CW-1:0] q_reg, q_next;
    logic [CW-1:0] k_reg, k_next;
    logic          src_reg, src_next;
    logic [RW-1:0] rec_p_reg, rec_p_next;
    logic [RW-1:0] rec_q_reg, rec_q_next;
    logic [LW-1:0] lenp_reg, lenp_next;
    logic [LW-1:0] lenq_reg, lenq_next;
    logic [LW-1:0] c_reg, c_next;
    logic [7:0]    cp_reg, cp_next;
    logic          winq_reg, winq_next;
    logic          cpyq_reg, cpyq_next;

    logic [RW-1:0] ord_src;
    logic [CW:0]   sum_mid, sum_hi;

    assign ord_src = src_reg ? rsp.ord_b_data : rsp.ord_a_data;
    assign sum_mid = {1'b0, lo_reg} + {1'b0, width_reg};
    assign sum_hi  = {1'b0, lo_reg} + {width_reg, 1'b0};
    assign bank    = src_reg;

    // Merge sort sequencer: at most one memory access per step
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        width_next = width_reg;
        lo_next    = lo_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        k_next     = k_reg;
        src_next   = src_reg;
        rec_p_next = rec_p_reg;
        rec_q_next = rec_q_reg;
        lenp_next  = lenp_reg;
        lenq_next  = lenq_reg;
        c_next     = c_reg;
        cp_next    = cp_reg;
        winq_next  = winq_reg;
        cpyq_next  = cpyq_reg;
        done       = 1'b0;
        req             = '0;
        req.key_addr    = {rec_p_reg, c_reg[PW-1:0]};
        req.len_addr    = rec_p_reg;
        req.ord_rd_addr = p_reg[RW-1:0];
        req.ord_wr_bank = ~src_reg;
        req.ord_wr_addr = k_reg[RW-1:0];
        req.ord_wr_data = winq_reg ? rec_q_reg : rec_p_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next   = count;
                    i_next   = '0;
                    src_next = 1'b0;
                    state_next = (count == '0) ? S_DONE : S_INIT;
                end
            end
            S_INIT:
            begin
                req.ord_wr_en   = 1'b1;
                req.ord_wr_bank = 1'b0;
                req.ord_wr_addr = i_reg[RW-1:0];
                req.ord_wr_data = i_reg[RW-1:0];
                i_next = i_reg + 1'b1;
                if (i_next == n_reg)
                begin
                    width_next = CW'(1);
                    lo_next    = '0;
                    state_next = (n_reg < CW'(2)) ? S_DONE : S_CHUNK;
                end
            end
            S_CHUNK:
            begin
                if (lo_reg >= n_reg)
                begin
                    // pass complete
                    src_next = ~src_reg;
                    lo_next  = '0;
                    width_next = CW'({width_reg, 1'b0});
                    if ({width_reg, 1'b0} >= {1'b0, n_reg})
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    mid_next = (sum_mid < {1'b0, n_reg}) ? sum_mid[CW-1:0] : n_reg;
                    hi_next  = (sum_hi < {1'b0, n_reg}) ? sum_hi[CW-1:0] : n_reg;
                    p_next   = lo_reg;
                    q_next   = mid_next;
                    k_next   = lo_reg;
                    state_next = S_SEL;
                end
            end
            S_SEL:
            begin
                priority if (p_reg < mid_reg && q_reg < hi_reg)
                begin
                    state_next = S_RDP;
                end
                else if (p_reg < mid_reg)
                begin
                    cpyq_next  = 1'b0;
                    state_next = S_CPY;
                end
                else if (q_reg < hi_reg)
                begin
                    cpyq_next  = 1'b1;
                    state_next = S_CPY;
                end
                else
                begin
                    lo_next    = hi_reg;
                    state_next = S_CHUNK;
                end
            end
            S_RDP:
            begin
                req.ord_rd_addr = p_reg[RW-1:0];
                state_next = S_RDQ;
            end
            S_RDQ:
            begin
                rec_p_next      = ord_src;
                req.ord_rd_addr = q_reg[RW-1:0];
                state_next = S_LENP;
            end
            S_LENP:
            begin
                rec_q_next   = ord_src;
                req.len_addr = rec_p_reg;
                state_next = S_LENQ;
            end
            S_LENQ:
            begin
                lenp_next    = rsp.len_data;
                req.len_addr = rec_q_reg;
                c_next       = '0;
                state_next = S_LENC;
            end
            S_LENC:
            begin
                lenq_next  = rsp.len_data;
                state_next = S_CHP;
            end
            S_CHP:
            begin
                if (c_reg < lenp_reg && c_reg < lenq_reg)
                begin
                    req.key_addr = {rec_p_reg, c_reg[PW-1:0]};
                    state_next = S_CHQ;
                end
                else
                begin
                    // common prefix: shorter key first, ties keep load order
                    winq_next  = lenp_reg > lenq_reg;
                    state_next = S_WR;
                end
            end
            S_CHQ:
            begin
                cp_next      = rsp.key_data;
                req.key_addr = {rec_q_reg, c_reg[PW-1:0]};
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (cp_reg != rsp.key_data)
                begin
                    winq_next  = cp_reg > rsp.key_data;
                    state_next = S_WR;
                end
                else
                begin
                    c_next     = c_reg + 1'b1;
                    state_next = S_CHP;
                end
            end
            S_WR:
            begin
                req.ord_wr_en = 1'b1;
                k_next = k_reg + 1'b1;
                if (winq_reg)
                begin
                    q_next = q_reg + 1'b1;
                end
                else
                begin
                    p_next = p_reg + 1'b1;
                end
                state_next = S_SEL;
            end
            S_CPY:
            begin
                req.ord_rd_addr = cpyq_reg ? q_reg[RW-1:0] : p_reg[RW-1:0];
                state_next = S_CPYW;
            end
            S_CPYW:
            begin
                req.ord_wr_en   = 1'b1;
                req.ord_wr_data = ord_src;
                k_next = k_reg + 1'b1;
                if (cpyq_reg)
                begin
                    q_next = q_reg + 1'b1;
                end
                else
                begin
                    p_next = p_reg + 1'b1;
                end
                state_next = S_SEL;
            end
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            src_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            src_reg   <= src_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        i_reg     <= i_next;
        width_reg <= width_next;
        lo_reg    <= lo_next;
        mid_reg   <= mid_next;
        hi_reg    <= hi_next;
        p_reg     <= p_next;
        q_reg     <= q_next;
        k_reg     <= k_next;
        rec_p_reg <= rec_p_next;
        rec_q_reg <= rec_q_next;
        lenp_reg  <= lenp_next;
        lenq_reg  <= lenq_next;
        c_reg     <= c_next;
        cp_reg    <= cp_next;
        winq_reg  <= winq_next;
        cpyq_reg  <= cpyq_next;
    end

endmodule

/* rtl/core/sort_records_by_string_key.sv */
// Record sorter by byte-string key. Clear, push-character and close commands
// complete one per cycle while the result register is free or being taken,
// with their result registered the next cycle. A read of an already sorted
// set goes through the order table, then the value, length and key memories,
// then the output register. The first read after any clear or successful
// close runs a stable merge sort first, holding tready low: it sets up the
// order table, then runs ceil(log2 n) merge passes, in which every key byte
// comes through the single read port of the key memory.
module sort_records_by_string_key (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // key_char[7:0], record_value[39:8], read_index[49:40], read_pos[55:50]
    input  logic [55:0] s_axis_tdata,
    // command[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_value[31:0], out_char[39:32], out_count[50:40], zero fill above
    output logic [55:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]  m_axis_tuser
);

    localparam int CW = srk_pkg::CNT_W;
    localparam int RW = srk_pkg::RIDX_W;
    localparam int LW = srk_pkg::LEN_W;
    localparam int PW = srk_pkg::KPOS_W;

    localparam logic [2:0] T_IDLE = 3'd0;
    localparam logic [2:0] T_SORT = 3'd1;
    localparam logic [2:0] T_ORD  = 3'd2;
    localparam logic [2:0] T_SLOT = 3'd3;
    localparam logic [2:0] T_OUT  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [LW-1:0]     open_reg, open_next;
    logic              sorted_reg, sorted_next;
    logic              bank_reg, bank_next;
    logic [RW-1:0]     ridx_reg, ridx_next;
    logic [PW-1:0]     rpos_reg, rpos_next;
    logic              ovalid_reg, ovalid_next;
    logic [1:0]        ostat_reg, ostat_next;
    logic signed [31:0] oval_reg, oval_next;
    logic [7:0]        ochar_reg, ochar_next;
    logic [CW-1:0]     ocnt_reg, ocnt_next;

    logic [1:0]        command;
    logic [7:0]        key_char;
    logic signed [31:0] record_value;
    logic [RW-1:0]     read_index;
    logic [PW-1:0]     read_pos;
    logic              accept;
    logic              sort_start;
    logic              room;

    logic              key_we, len_we;
    logic [srk_pkg::KEY_AW-1:0] key_raddr;
    logic [RW-1:0]     len_raddr, ord_raddr, slot;
    logic [7:0]        key_rdata;
    logic [LW-1:0]     len_rdata;
    logic [31:0]       val_rdata;
    logic [RW-1:0]     ord_a_rdata, ord_b_rdata;

    srk_pkg::srk_req_t req;
    srk_pkg::srk_rsp_t rsp;
    logic              sort_done;
    logic              sort_bank;

    assign command      = s_axis_tuser;
    assign key_char     = s_axis_tdata[7:0];
    assign record_value = s_axis_tdata[39:8];
    assign read_index   = s_axis_tdata[49:40];
    assign read_pos     = s_axis_tdata[55:50];

    assign s_axis_tready = (state_reg == T_IDLE) && (!ovalid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign room          = count_reg < CW'(srk_pkg::MAX_RECORDS);

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tuser  = ostat_reg;
    assign m_axis_tdata  = {5'd0, ocnt_reg, ochar_reg, oval_reg};

    // Order, length and key memory read ports go to the sorter while it runs
    assign slot      = bank_reg ? ord_b_rdata : ord_a_rdata;
    assign ord_raddr = (state_reg == T_SORT) ? req.ord_rd_addr : ridx_reg;
    assign len_raddr = (state_reg == T_SORT) ? req.len_addr : slot;
    assign key_raddr = (state_reg == T_SORT) ? req.key_addr : {slot, rpos_reg};

    assign key_we = accept && command == srk_pkg::CMD_PUSH && room
                    && open_reg < LW'(srk_pkg::KEY_CHARS);
    assign len_we = accept && command == srk_pkg::CMD_CLOSE && room;

    assign rsp.key_data   = key_rdata;
    assign rsp.len_data   = len_rdata;
    assign rsp.ord_a_data = ord_a_rdata;
    assign rsp.ord_b_data = ord_b_rdata;

    srk_ram #(.WIDTH(8), .DEPTH(srk_pkg::KEY_DEPTH)) u_key (
        .clk   (clk),
        .we    (key_we),
        .waddr ({count_reg[RW-1:0], open_reg[PW-1:0]}),
        .wdata (key_char),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    srk_ram #(.WIDTH(LW), .DEPTH(srk_pkg::MAX_RECORDS)) u_len (
        .clk   (clk),
        .we    (len_we),
        .waddr (count_reg[RW-1:0]),
        .wdata (open_reg),
        .raddr (len_raddr),
        .rdata (len_rdata)
    );

    srk_ram #(.WIDTH(32), .DEPTH(srk_pkg::MAX_RECORDS)) u_val (
        .clk   (clk),
        .we    (len_we),
        .waddr (count_reg[RW-1:0]),
        .wdata (record_value),
        .raddr (slot),
        .rdata (val_rdata)
    );

    srk_ram #(.WIDTH(RW), .DEPTH(srk_pkg::MAX_RECORDS)) u_ord_a (
        .clk   (clk),
        .we    (req.ord_wr_en && !req.ord_wr_bank),
        .waddr (req.ord_wr_addr),
        .wdata (req.ord_wr_data),
        .raddr (ord_raddr),
        .rdata (ord_a_rdata)
    );

    srk_ram #(.WIDTH(RW), .DEPTH(srk_pkg::MAX_RECORDS)) u_ord_b (
        .clk   (clk),
        .we    (req.ord_wr_en && req.ord_wr_bank),
        .waddr (req.ord_wr_addr),
        .wdata (req.ord_wr_data),
        .raddr (ord_raddr),
        .rdata (ord_b_rdata)
    );

    srk_sorter u_sorter (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sort_start),
        .count (count_reg),
        .rsp   (rsp),
        .req   (req),
        .done  (sort_done),
        .bank  (sort_bank)
    );

    // Command handling and result register
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        open_next   = open_reg;
        sorted_next = sorted_reg;
        bank_next   = bank_reg;
        ridx_next   = ridx_reg;
        rpos_next   = rpos_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        ostat_next  = ostat_reg;
        oval_next   = oval_reg;
        ochar_next  = ochar_reg;
        ocnt_next   = ocnt_reg;
        sort_start  = 1'b0;

        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    ostat_next = srk_pkg::ST_OK;
                    oval_next  = '0;
                    ochar_next = '0;
                    unique case (command)
                        srk_pkg::CMD_CLEAR:
                        begin
                            count_next  = '0;
                            open_next   = '0;
                            sorted_next = 1'b0;
                            ovalid_next = 1'b1;
                        end
                        srk_pkg::CMD_PUSH:
                        begin
                            if (key_we)
                            begin
                                open_next = open_reg + 1'b1;
                            end
                            else
                            begin
                                ostat_next = srk_pkg::ST_OVERFLOW;
                            end
                            ovalid_next = 1'b1;
                        end
                        srk_pkg::CMD_CLOSE:
                        begin
                            if (room)
                            begin
                                count_next  = count_reg + 1'b1;
                                sorted_next = 1'b0;
                            end
                            else
                            begin
                                ostat_next = srk_pkg::ST_OVERFLOW;
                            end
                            open_next   = '0;
                            ovalid_next = 1'b1;
                        end
                        srk_pkg::CMD_READ:
                        begin
                            ridx_next  = read_index;
                            rpos_next  = read_pos;
                            sort_start = !sorted_reg;
                            state_next = sorted_reg ? T_ORD : T_SORT;
                        end
                        default:
                        begin
                            ovalid_next = 1'b1;
                        end
                    endcase
                    ocnt_next = count_next;
                end
            end
            T_SORT:
            begin
                if (sort_done)
                begin
                    sorted_next = 1'b1;
                    bank_next   = sort_bank;
                    state_next  = T_ORD;
                end
            end
            T_ORD:
            begin
                if ({1'b0, ridx_reg} >= count_reg)
                begin
                    ostat_next  = srk_pkg::ST_RANGE;
                    ovalid_next = 1'b1;
                    state_next  = T_IDLE;
                end
                else
                begin
                    state_next = T_SLOT;
                end
            end
            T_SLOT:
            begin
                state_next = T_OUT;
            end
            T_OUT:
            begin
                oval_next   = val_rdata;
                ochar_next  = ({1'b0, rpos_reg} < len_rdata) ? key_rdata : 8'd0;
                ovalid_next = 1'b1;
                state_next  = T_IDLE;
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= T_IDLE;
            count_reg  <= '0;
            open_reg   <= '0;
            sorted_reg <= 1'b0;
            bank_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            open_reg   <= open_next;
            sorted_reg <= sorted_next;
            bank_reg   <= bank_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ridx_reg  <= ridx_next;
        rpos_reg  <= rpos_next;
        ostat_reg <= ostat_next;
        oval_reg  <= oval_next;
        ochar_reg <= ochar_next;
        ocnt_reg  <= ocnt_next;
    end

endmodule

/* rtl/core/srk_checker.sv */
`include "sort_records_by_string_key_defines.svh"

module srk_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [55:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    logic in_xfer;

    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // Result held while stalled
    `SRK_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "result changed while stalled")

    // Status is a defined code
    `SRK_ASSERT_NOW(a_status_code, m_axis_tvalid,
        m_axis_tuser == srk_pkg::ST_OK || m_axis_tuser == srk_pkg::ST_OVERFLOW
        || m_axis_tuser == srk_pkg::ST_RANGE, "undefined status")

    // Record count never exceeds capacity
    `SRK_ASSERT_NOW(a_count_cap, m_axis_tvalid,
        m_axis_tdata[50:40] <= 11'(srk_pkg::MAX_RECORDS), "count over capacity")

    // Clear answers next cycle with an empty store
    `SRK_ASSERT_NEXT(a_clear_result, in_xfer && s_axis_tuser == srk_pkg::CMD_CLEAR,
        m_axis_tvalid && m_axis_tuser == srk_pkg::ST_OK && m_axis_tdata[50:40] == 11'd0,
        "clear result wrong")

endmodule

bind sort_records_by_string_key srk_checker u_srk_checker (.*);
